>>> rtl/game_port_paddle_timer_core_assert.svh
// Assertion macros shared by the game-port paddle timer RTL.
`ifndef GAME_PORT_PADDLE_TIMER_CORE_ASSERT_SVH
`define GAME_PORT_PADDLE_TIMER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define GPP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gpp assertion failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define GPP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gpp assertion failed");

`endif

>>> rtl/gpp_pkg.sv
// Types, addresses and the axis-to-delay arithmetic of the game-port paddle timer.
package gpp_pkg;

    localparam int AXES     = 4;
    localparam int AXIS_W   = 16;
    localparam int CYCLE_W  = 32;
    localparam int DELAY_W  = 12;

    localparam logic [7:0] ADDR_BUTTON0 = 8'h61;
    localparam logic [7:0] ADDR_BUTTON_END = 8'h64;
    localparam logic [7:0] ADDR_PADDLE0 = 8'h64;
    localparam logic [7:0] ADDR_PADDLE_END = 8'h68;
    localparam logic [7:0] ADDR_TRIGGER = 8'h70;
    localparam logic [7:0] BIT_HIGH     = 8'h80;
    localparam logic [8:0] SCALED_TOP   = 9'd255;
    localparam logic [8:0] SCALED_BOOST = 9'd280;

    typedef struct packed {
        logic                 load;
        logic [CYCLE_W-1:0]   cycle_count;
    } paddle_ctrl_t;

    // Delay in cycles for one axis position. The position is biased to 0..65535,
    // divided by 257 (estimate from the high byte, then one correction), the top
    // value is boosted, and the result is scaled by 2816/255. Since 2816 is 11*256,
    // floor(s*2816/255) = t + floor(t/255) with t = 11*s.
    function automatic logic [DELAY_W-1:0] axis_delay(input logic [AXIS_W-1:0] axis);
        logic [15:0]        biased;
        logic [7:0]         est;
        logic [16:0]        back;
        logic [8:0]         scaled;
        logic [DELAY_W-1:0] tri_s;
        logic [DELAY_W-1:0] quot;
        biased = axis ^ 16'h8000;
        est    = biased[15:8];
        back   = {1'b0, est, 8'h00} + {9'd0, est};
        if (back > {1'b0, biased})
            scaled = {1'b0, est - 8'd1};
        else
            scaled = {1'b0, est};
        if (scaled == SCALED_TOP)
            scaled = SCALED_BOOST;
        tri_s = ({3'd0, scaled} << 3) + ({3'd0, scaled} << 1) + {3'd0, scaled};
        quot  = (tri_s + 12'd1 + (tri_s >> 8)) >> 8;
        return tri_s + quot;
    endfunction

endpackage

>>> rtl/gpp_paddle.sv
// One paddle timer: deadline register, reload on trigger and comparator.
module gpp_paddle
    import gpp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  paddle_ctrl_t             ctrl,
    input  logic signed [AXIS_W-1:0] axis,
    output logic                     active
);

    logic [CYCLE_W-1:0] deadline_reg;
    logic [CYCLE_W-1:0] deadline_next;

    always_comb
    begin
        deadline_next = deadline_reg;
        if (ctrl.load)
            deadline_next = ctrl.cycle_count + {{(CYCLE_W-DELAY_W){1'b0}}, axis_delay(axis)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            deadline_reg <= '0;
        else
            deadline_reg <= deadline_next;
    end

    // The comparator sees the deadline as left by every earlier beat.
    assign active = ctrl.cycle_count < deadline_reg;

endmodule

>>> rtl/game_port_paddle_timer_core.sv
// Top level of the game-port paddle timer: bus beat pipeline, decode and result.
// One bus access is accepted per cycle, back to back, and its byte is presented on
// the result side after it has passed through its stages: an input register, then
// one pass that decodes the address, compares the cycle count against the paddle
// deadlines and reloads all deadlines on an access to 0x70, then the result
// register. That pass holds the 32-bit deadline add and compare, which set the
// clock rate. A trigger beat takes effect for the very next beat. Reads return
// bit 7 as button or paddle level ORed with the floating-bus byte; writes return
// zero. Back-pressure on the result side stalls the input only once both
// registers are full.
`include "game_port_paddle_timer_core_assert.svh"

module game_port_paddle_timer_core
    import gpp_pkg::*;
#(
    parameter int PADDLES = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // address_low[7:0], cycle_count[39:8], buttons_pressed[42:40], axis_zero[58:43],
    // axis_one[74:59], axis_two[90:75], axis_three[106:91], floating_bus[114:107]
    input  logic [119:0] s_tdata,
    // write_flag[0]
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // read_data[7:0]
    output logic [7:0]   m_tdata
);

    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    logic [7:0]               s1_addr_reg;
    logic                     s1_write_reg;
    logic [CYCLE_W-1:0]       s1_cycle_reg;
    logic [2:0]               s1_buttons_reg;
    logic signed [AXIS_W-1:0] s1_axis_reg [AXES];
    logic [7:0]               s1_bus_reg;

    logic       out_valid_reg;
    logic       out_valid_next;
    logic [7:0] out_data_reg;
    logic [7:0] out_data_next;

    logic            advance;
    logic            in_take;
    logic            pass_beat;
    logic            plain_read;
    logic            is_button;
    logic            is_paddle;
    logic            is_trigger;
    logic            bit_hi;
    logic [1:0]      button_idx;
    logic [AXES-1:0] paddle_active;
    paddle_ctrl_t    ctrl;

    assign advance   = !out_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || advance;
    assign in_take   = s_tvalid && s_tready;
    assign pass_beat = s1_valid_reg && advance;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s_tready)
            s1_valid_next = s_tvalid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_addr_reg    <= s_tdata[7:0];
            s1_write_reg   <= s_tuser;
            s1_cycle_reg   <= s_tdata[39:8];
            s1_buttons_reg <= s_tdata[42:40];
            s1_axis_reg[0] <= s_tdata[58:43];
            s1_axis_reg[1] <= s_tdata[74:59];
            s1_axis_reg[2] <= s_tdata[90:75];
            s1_axis_reg[3] <= s_tdata[106:91];
            s1_bus_reg     <= s_tdata[114:107];
        end
    end

    assign is_button  = (s1_addr_reg >= ADDR_BUTTON0) && (s1_addr_reg < ADDR_BUTTON_END);
    assign is_paddle  = (s1_addr_reg >= ADDR_PADDLE0) && (s1_addr_reg < ADDR_PADDLE_END);
    assign is_trigger = s1_addr_reg == ADDR_TRIGGER;
    assign button_idx = s1_addr_reg[1:0] - 2'd1;
    assign plain_read = pass_beat && !s1_write_reg && !is_button && !is_paddle;

    // Deadlines move only when the beat actually passes to the result register.
    assign ctrl.load        = pass_beat && is_trigger;
    assign ctrl.cycle_count = s1_cycle_reg;

    for (genvar p = 0; p < AXES; p++)
    begin : g_paddle
        if (p < PADDLES)
        begin : g_on
            gpp_paddle u_paddle (
                .clk    (clk),
                .rst_n  (rst_n),
                .ctrl   (ctrl),
                .axis   (s1_axis_reg[p]),
                .active (paddle_active[p])
            );
        end
        else
        begin : g_off
            assign paddle_active[p] = 1'b0;
        end
    end

    always_comb
    begin
        priority if (is_button)
            bit_hi = s1_buttons_reg[button_idx];
        else if (is_paddle)
            bit_hi = paddle_active[s1_addr_reg[1:0]];
        else
            bit_hi = 1'b0;
        if (s1_write_reg)
            out_data_next = 8'h00;
        else
            out_data_next = (bit_hi ? BIT_HIGH : 8'h00) | s1_bus_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pass_beat)
            out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `GPP_ASSERT_NEXT(a_write_returns_zero, pass_beat && s1_write_reg, m_tdata == 8'h00)
    `GPP_ASSERT_NEXT(a_pass_gives_result, pass_beat, m_tvalid)
    `GPP_ASSERT_NOW(a_full_blocks_input, out_valid_reg && !m_tready && s1_valid_reg, !s_tready)
    `GPP_ASSERT_NEXT(a_plain_read_is_bus, plain_read, m_tdata == $past(s1_bus_reg))

endmodule
